[src/psa_pkg.sv]
`default_nettype none

package psa_pkg;

  localparam int NUM_POOLS = 8;
  localparam int SIZE_BITS = 40;

  localparam int BYTE_W   = 40;
  localparam int ALIGN_W  = 32;
  localparam int ID_W     = 32;
  localparam int IDX_W    = 3;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int POOL_W   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

  localparam logic [BYTE_W-1:0] SIZE_MASK =
    (SIZE_BITS >= BYTE_W) ? {BYTE_W{1'b1}} : ({BYTE_W{1'b1}} >> (BYTE_W - SIZE_BITS));

  typedef enum logic [FUNC_W-1:0] {
    FN_DEFINE = 2'd0,
    FN_ALLOC  = 2'd1,
    FN_FREE   = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_NOSPACE   = 3'd2,
    ST_NOTNEWEST = 3'd3,
    ST_ZEROALIGN = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  capacity;
    logic [BYTE_W-1:0]  free_space;
    logic [ALIGN_W-1:0] alignment;
    logic [ID_W-1:0]    next_id;
    logic [BYTE_W-1:0]  peak_used;
    logic [ALIGN_W-1:0] peak_align;
    logic               opened;
  } pool_t;

  typedef struct packed {
    logic              en;
    logic [POOL_W-1:0] idx;
    pool_t             data;
  } pool_wr_t;

endpackage

`default_nettype wire

[src/psa_req_if.sv]
`default_nettype none

interface psa_req_if import psa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [IDX_W-1:0]   pool_index;
  logic [BYTE_W-1:0]  byte_count;
  logic [ALIGN_W-1:0] align_value;
  logic [ID_W-1:0]    block_id;

  modport source (
    output valid, func, pool_index, byte_count, align_value, block_id,
    input  ready
  );

  modport sink (
    input  valid, func, pool_index, byte_count, align_value, block_id,
    output ready
  );
endinterface

`default_nettype wire

[src/psa_rsp_if.sv]
`default_nettype none

interface psa_rsp_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   offset;
  logic [BYTE_W-1:0]   aligned_size;
  logic [ID_W-1:0]     new_block_id;
  logic [BYTE_W-1:0]   peak_occupied;
  logic [ALIGN_W-1:0]  peak_alignment;
  logic                all_empty;

  modport source (
    output valid, status, offset, aligned_size, new_block_id, peak_occupied,
           peak_alignment, all_empty,
    input  ready
  );

  modport sink (
    input  valid, status, offset, aligned_size, new_block_id, peak_occupied,
           peak_alignment, all_empty,
    output ready
  );
endinterface

`default_nettype wire

[src/psa_div.sv]
`default_nettype none

module psa_div import psa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [BYTE_W-1:0]  dividend,
  input  wire logic [ALIGN_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [ALIGN_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(BYTE_W);

  logic [CNT_W-1:0]   cnt;
  logic [BYTE_W-1:0]  dvd;
  logic [ALIGN_W-1:0] dsr;
  logic [ALIGN_W:0]   trial;
  logic               fits;

  assign trial = {remainder, dvd[BYTE_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(BYTE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= fits ? ALIGN_W'(trial - {1'b0, dsr}) : trial[ALIGN_W-1:0];
      dvd       <= dvd << 1;
    end
  end

endmodule

`default_nettype wire

[src/psa_pool_bank.sv]
`default_nettype none

module psa_pool_bank import psa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [POOL_W-1:0] rd_idx,
  output pool_t                  rd,
  input  wire pool_wr_t          wr,
  output logic                   all_empty
);

  pool_t                pools [NUM_POOLS];
  logic [NUM_POOLS-1:0] held;
  logic [NUM_POOLS-1:0] held_after;
  logic                 wr_held;

  assign rd      = pools[rd_idx];
  assign wr_held = wr.data.opened && (wr.data.free_space != wr.data.capacity);

  always_comb begin
    held_after = held;
    if (wr.en) begin
      held_after[wr.idx] = wr_held;
    end
  end

  assign all_empty = ~|held_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      pools <= '{default: '0};
      held  <= '0;
    end else if (wr.en) begin
      pools[wr.idx] <= wr.data;
      held[wr.idx]  <= wr_held;
    end
  end

endmodule

`default_nettype wire

[src/pooled_stack_allocator.sv]
// Pooled stack allocator: NUM_POOLS linear stack pools behind one request
// channel (req) and one response channel (rsp), valid/ready on both.
// Each request transaction gives exactly one response transaction.
// func selects define, allocate, free-newest or query; the response
// carries a status code, the new block's offset, rounded size and id, the
// pool's peak marks after the request, and whether every opened pool is
// empty.
// From acceptance the sequencer steps through PREP and FINISH for define,
// free, query and a zero-alignment allocate; an allocate with a non-zero
// pool alignment adds DIV and ROUND between them. DIV waits on the shared
// restoring divider, which retires one dividend bit per cycle over the
// 40-bit size to get the remainder used for rounding. req.ready is high
// only while the sequencer is idle, so one request is in flight at a time;
// the next can be taken in the cycle after the last response is registered.
// A stalled response holds in the output register; a new request may be
// accepted meanwhile, and its result waits until the register frees.
// Synchronous reset clears every pool to zero and empties both channels.
`default_nettype none

module pooled_stack_allocator import psa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  psa_req_if.sink   req,
  psa_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_DIV    = 5'b00100,
    S_ROUND  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  func_t              cur_func;
  logic [POOL_W-1:0]  cur_pidx;
  logic               cur_oor;
  logic [BYTE_W-1:0]  cur_bytes;
  logic [ALIGN_W-1:0] cur_align;
  logic [ID_W-1:0]    cur_bid;
  logic [BYTE_W-1:0]  room;
  logic [BYTE_W-1:0]  rnd;
  logic               over;

  pool_t    rd;
  pool_wr_t wr;
  logic     all_empty;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [ALIGN_W-1:0] div_rem;

  logic               accept;
  logic               commit;
  logic               run_div;
  logic [BYTE_W:0]    r_full;
  logic [BYTE_W-1:0]  used;
  status_t            res_status;
  logic [BYTE_W-1:0]  res_offset;
  logic [BYTE_W-1:0]  res_asize;
  logic [ID_W-1:0]    res_nid;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign commit    = (state == S_FINISH) && (!rsp.valid || rsp.ready);
  assign run_div   = !cur_oor && (cur_func == FN_ALLOC) && (rd.alignment != '0);
  assign div_start = (state == S_PREP) && run_div;

  psa_pool_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (cur_pidx),
    .rd        (rd),
    .wr        (wr),
    .all_empty (all_empty)
  );

  psa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cur_bytes),
    .divisor   (rd.alignment),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_PREP;
      S_PREP:   state_next = run_div ? S_DIV : S_FINISH;
      S_DIV:    if (div_done) state_next = S_ROUND;
      S_ROUND:  state_next = S_FINISH;
      S_FINISH: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func  <= func_t'(req.func);
      cur_pidx  <= POOL_W'(req.pool_index);
      cur_oor   <= 32'(req.pool_index) >= NUM_POOLS;
      cur_bytes <= req.byte_count & SIZE_MASK;
      cur_align <= req.align_value;
      cur_bid   <= req.block_id;
    end
    if (state == S_PREP) begin
      room <= rd.capacity - rd.free_space;
    end
    if (state == S_ROUND) begin
      rnd  <= (r_full > {1'b0, SIZE_MASK}) ? SIZE_MASK : r_full[BYTE_W-1:0];
      over <= r_full > {1'b0, SIZE_MASK};
    end
  end

  // round up: size minus remainder, plus one alignment step when inexact
  assign r_full = {1'b0, cur_bytes} - (BYTE_W+1)'(div_rem)
                + ((div_rem != '0) ? (BYTE_W+1)'(rd.alignment) : '0);
  assign used   = room + rnd;

  always_comb begin
    wr         = '{en: 1'b0, idx: cur_pidx, data: rd};
    res_status = ST_OK;
    res_offset = '0;
    res_asize  = '0;
    res_nid    = '0;
    if (cur_oor) begin
      res_status = ST_IGNORED;
    end else begin
      wr.en = commit;
      unique case (cur_func)
        FN_DEFINE: begin
          if (cur_bytes == '0) begin
            res_status = ST_IGNORED;
          end else begin
            wr.data.capacity   = cur_bytes;
            wr.data.free_space = cur_bytes;
            wr.data.alignment  = cur_align;
          end
        end
        FN_ALLOC: begin
          wr.data.opened = 1'b1;
          if (rd.alignment == '0) begin
            res_status = ST_ZEROALIGN;
          end else begin
            res_asize = rnd;
            if (over || (rnd > rd.free_space)) begin
              res_status = ST_NOSPACE;
            end else begin
              res_offset         = room;
              res_nid            = rd.next_id;
              wr.data.free_space = rd.free_space - rnd;
              wr.data.next_id    = rd.next_id + ID_W'(1);
              if (cur_align > rd.peak_align) wr.data.peak_align = cur_align;
              if (used > rd.peak_used) wr.data.peak_used = used;
            end
          end
        end
        FN_FREE: begin
          if (cur_bid != (rd.next_id - ID_W'(1))) begin
            res_status = ST_NOTNEWEST;
          end else begin
            wr.data.next_id    = rd.next_id - ID_W'(1);
            wr.data.free_space = (cur_bytes >= room) ? rd.capacity
                                                     : rd.free_space + cur_bytes;
          end
        end
        FN_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status         <= res_status;
      rsp.offset         <= res_offset;
      rsp.aligned_size   <= res_asize;
      rsp.new_block_id   <= res_nid;
      rsp.peak_occupied  <= cur_oor ? '0 : wr.data.peak_used;
      rsp.peak_alignment <= cur_oor ? '0 : wr.data.peak_align;
      rsp.all_empty      <= all_empty;
    end
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_wr_finish: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_FINISH))
    else $error("pool write outside finish step");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_FINISH))
    else $error("response raised without finish step");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside divide step");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psa_pkg::*;

  typedef struct packed {
    func_t              func;
    logic [IDX_W-1:0]   pool;
    logic [BYTE_W-1:0]  bytes;
    logic [ALIGN_W-1:0] align;
    logic [ID_W-1:0]    bid;
  } pool_request_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  offset;
    logic [BYTE_W-1:0]  aligned_size;
    logic [ID_W-1:0]    new_block_id;
    logic [BYTE_W-1:0]  peak_occupied;
    logic [ALIGN_W-1:0] peak_alignment;
    logic               all_empty;
  } pool_result_t;

  class pool_scoreboard;
    logic [BYTE_W-1:0]  cap [NUM_POOLS];
    logic [BYTE_W-1:0]  free_b [NUM_POOLS];
    logic [ALIGN_W-1:0] pool_align [NUM_POOLS];
    logic [ID_W-1:0]    next_id [NUM_POOLS];
    logic [BYTE_W-1:0]  pk_used [NUM_POOLS];
    logic [ALIGN_W-1:0] pk_align [NUM_POOLS];
    bit                 opened [NUM_POOLS];
    pool_result_t       expected_results [$];
    int                 errors;

    function new();
      errors = 0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        cap[p] = '0;
        free_b[p] = '0;
        pool_align[p] = '0;
        next_id[p] = '0;
        pk_used[p] = '0;
        pk_align[p] = '0;
        opened[p] = 1'b0;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function pool_result_t note_request(pool_request_t rq);
      pool_result_t e;
      int p;
      logic [63:0] a, q, rounded, want;
      logic [ID_W-1:0] top;
      bit over;
      e = '0;
      e.status = ST_OK;
      p = rq.pool;
      if (p >= NUM_POOLS) begin
        e.status = ST_IGNORED;
      end else begin
        case (rq.func)
          FN_DEFINE: begin
            if ((rq.bytes & SIZE_MASK) == '0) begin
              e.status = ST_IGNORED;
            end else begin
              cap[p] = rq.bytes & SIZE_MASK;
              free_b[p] = rq.bytes & SIZE_MASK;
              pool_align[p] = rq.align;
            end
          end
          FN_ALLOC: begin
            opened[p] = 1'b1;
            a = 64'(pool_align[p]);
            if (a == 0) begin
              e.status = ST_ZEROALIGN;
            end else begin
              want = 64'(rq.bytes & SIZE_MASK);
              q = want / a + 64'((want % a) != 0);
              over = q > 64'(SIZE_MASK) / a;
              rounded = over ? 64'(SIZE_MASK) : q * a;
              e.aligned_size = rounded[BYTE_W-1:0];
              if (over || rounded > 64'(free_b[p])) begin
                e.status = ST_NOSPACE;
              end else begin
                e.offset = cap[p] - free_b[p];
                free_b[p] = free_b[p] - rounded[BYTE_W-1:0];
                if (rq.align > pk_align[p]) pk_align[p] = rq.align;
                if (cap[p] - free_b[p] > pk_used[p]) pk_used[p] = cap[p] - free_b[p];
                e.new_block_id = next_id[p];
                next_id[p] = next_id[p] + 1'b1;
              end
            end
          end
          FN_FREE: begin
            top = next_id[p] - 1'b1;
            if (rq.bid != top) begin
              e.status = ST_NOTNEWEST;
            end else begin
              next_id[p] = top;
              if ((rq.bytes & SIZE_MASK) >= cap[p] - free_b[p]) free_b[p] = cap[p];
              else free_b[p] = free_b[p] + (rq.bytes & SIZE_MASK);
            end
          end
          default: ;
        endcase
        e.peak_occupied = pk_used[p];
        e.peak_alignment = pk_align[p];
      end
      e.all_empty = 1'b1;
      for (int i = 0; i < NUM_POOLS; i++)
        if (opened[i] && free_b[i] != cap[i]) e.all_empty = 1'b0;
      expected_results.push_back(e);
      return e;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(pool_result_t got);
      pool_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected response", 64'(got.status), 64'(0));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.offset !== want.offset)
          report_mismatch("offset", 64'(got.offset), 64'(want.offset));
        if (got.aligned_size !== want.aligned_size)
          report_mismatch("aligned_size", 64'(got.aligned_size), 64'(want.aligned_size));
        if (got.new_block_id !== want.new_block_id)
          report_mismatch("new_block_id", 64'(got.new_block_id), 64'(want.new_block_id));
        if (got.peak_occupied !== want.peak_occupied)
          report_mismatch("peak_occupied", 64'(got.peak_occupied), 64'(want.peak_occupied));
        if (got.peak_alignment !== want.peak_alignment)
          report_mismatch("peak_alignment", 64'(got.peak_alignment),
                          64'(want.peak_alignment));
        if (got.all_empty !== want.all_empty)
          report_mismatch("all_empty", 64'(got.all_empty), 64'(want.all_empty));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;
  bit   start_hold = 1'b0;
  int   hold_left = 0;

  pool_scoreboard sb = new();
  logic [BYTE_W-1:0] live_sz [NUM_POOLS][$];

  psa_req_if req_ch ();
  psa_rsp_if rsp_ch ();

  pooled_stack_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{status_t'(rsp_ch.status), rsp_ch.offset, rsp_ch.aligned_size,
                        rsp_ch.new_block_id, rsp_ch.peak_occupied, rsp_ch.peak_alignment,
                        rsp_ch.all_empty});
    if (start_hold) begin
      hold_left = 400;
      start_hold = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (calm) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= 30);
    end
  end

  task send_item(pool_request_t it);
    pool_result_t e;
    req_ch.valid       <= 1'b1;
    req_ch.func        <= it.func;
    req_ch.pool_index  <= it.pool;
    req_ch.byte_count  <= it.bytes;
    req_ch.align_value <= it.align;
    req_ch.block_id    <= it.bid;
    do @(posedge clk); while (!req_ch.ready);
    e = sb.note_request(it);
    if (e.status == ST_OK) begin
      case (it.func)
        FN_DEFINE: live_sz[it.pool].delete();
        FN_ALLOC:  live_sz[it.pool].push_back(e.aligned_size);
        FN_FREE:   if (live_sz[it.pool].size() > 0) void'(live_sz[it.pool].pop_back());
        default: ;
      endcase
    end
    if (!calm && $urandom_range(99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task put(func_t f, int p, logic [BYTE_W-1:0] b, logic [ALIGN_W-1:0] al, logic [ID_W-1:0] id);
    send_item('{f, IDX_W'(p), b, al, id});
  endtask

  function logic [ALIGN_W-1:0] pick_alignment();
    int k;
    k = $urandom_range(19);
    if (k == 0) return '0;
    if (k < 12) return ALIGN_W'(1) << $urandom_range(0, 8);
    if (k < 16) return ALIGN_W'($urandom_range(1, 100));
    if (k < 18) return $urandom;
    return ALIGN_W'(1);
  endfunction

  function pool_request_t make_item(bit junk);
    pool_request_t it;
    int p;
    int pick;
    logic [BYTE_W-1:0] space;
    p = $urandom_range(NUM_POOLS - 1);
    it.func = func_t'($urandom_range(3));
    it.pool = IDX_W'(p);
    it.bytes = BYTE_W'({$urandom, $urandom});
    it.align = $urandom;
    it.bid = $urandom;
    if (junk) return it;
    pick = $urandom_range(99);
    if (sb.cap[p] == '0 || pick < 10) begin
      it.func = FN_DEFINE;
      if ($urandom_range(9) < 8) it.bytes = BYTE_W'($urandom_range(1, 65536));
      else if ($urandom_range(1) == 0) it.bytes = '0;
      it.align = pick_alignment();
    end else if (pick < 55) begin
      it.func = FN_ALLOC;
      space = sb.free_b[p];
      if ($urandom_range(9) != 0)
        it.bytes = BYTE_W'({$urandom, $urandom} % (64'(space) / 3 + 2));
      if ($urandom_range(3) != 0) it.align = ALIGN_W'(1) << $urandom_range(0, 12);
    end else if (pick < 85) begin
      it.func = FN_FREE;
      if ($urandom_range(9) != 0) it.bid = sb.next_id[p] - 1'b1;
      if ($urandom_range(9) != 0)
        it.bytes = (live_sz[p].size() > 0) ? live_sz[p][$] : BYTE_W'($urandom_range(64));
    end else begin
      it.func = FN_QUERY;
    end
    return it;
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FN_QUERY;
    req_ch.pool_index = '0;
    req_ch.byte_count = '0;
    req_ch.align_value = '0;
    req_ch.block_id = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(FN_QUERY,  0, 0, 0, 0);
    put(FN_ALLOC,  0, 100, 8, 0);
    put(FN_DEFINE, 0, 0, 16, 0);
    put(FN_FREE,   0, 0, 0, 32'hFFFF_FFFF);
    put(FN_DEFINE, 0, 1000, 16, 0);
    put(FN_ALLOC,  0, 0, 0, 0);
    put(FN_ALLOC,  0, 17, 32'hFFFF_FFFF, 0);
    put(FN_ALLOC,  0, 2000, 4, 0);
    put(FN_ALLOC,  0, 40'hFF_FFFF_FFFF, 1, 0);
    put(FN_FREE,   0, 32, 0, 5);
    put(FN_FREE,   0, 8, 0, 0);
    put(FN_FREE,   0, 40'hFF_FFFF_FFFF, 0, 32'hFFFF_FFFF);
    put(FN_DEFINE, 7, 40'hFF_FFFF_FFFF, 1, 0);
    put(FN_ALLOC,  7, 40'hFF_FFFF_FFFF, 32'h8000_0001, 0);
    put(FN_ALLOC,  7, 1, 1, 0);
    put(FN_QUERY,  7, 0, 0, 0);
    put(FN_DEFINE, 7, 100, 3, 0);
    put(FN_ALLOC,  7, 10, 0, 0);
    put(FN_DEFINE, 1, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    put(FN_ALLOC,  1, 1, 0, 0);
    put(FN_ALLOC,  1, 40'hFF_0000_0000, 0, 0);
    put(FN_FREE,   7, 12, 0, 1);
    put(FN_DEFINE, 3, 64, 0, 0);
    put(FN_ALLOC,  3, 1, 1, 0);
    put(FN_QUERY,  5, 40'hAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

    for (int n = 0; n < 500; n++) begin
      if (n == 150) start_hold = 1'b1;
      calm = (n >= 300 && n < 400);
      send_item(make_item($urandom_range(99) < 8));
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** pooled_stack_allocator: PASSED **");
    end else begin
      $display("** pooled_stack_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** pooled_stack_allocator: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
